/* sv/bgm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bgm_pkg
// Shared widths, register indexes, reset values and result codes of the
// battery gauge reading monitor.
// ----------------------------------------------------------------------------
package bgm_pkg;

  // Field widths
  localparam int RAW_W     = 16;
  localparam int SHIFT_W   = 4;
  localparam int SCALE_W   = 12;
  localparam int MV_W      = 16;
  localparam int MV_FULL_W = RAW_W + SCALE_W - 8;  // product right-shifted by the Q8 point
  localparam int SOC_W     = 8;
  localparam int PCT_W     = 7;
  localparam int STATE_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Window depth default
  localparam int WINDOW_SAMPLES_DEF = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VCELL_SHIFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MV        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SOC_WHOLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_MV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ENTER     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_EXIT      = 3'd6;

  // Register reset values
  localparam logic [SHIFT_W-1:0] RST_VCELL_SHIFT   = 4'd4;
  localparam logic [SCALE_W-1:0] RST_MV_PER_COUNT  = 12'd320;
  localparam logic [MV_W-1:0]    RST_MAX_MV        = 16'd5000;
  localparam logic [SOC_W-1:0]   RST_MAX_SOC_WHOLE = 8'd110;
  localparam logic [MV_W-1:0]    RST_DEADBAND_MV   = 16'd20;
  localparam logic [PCT_W-1:0]   RST_LOW_ENTER     = 7'd20;
  localparam logic [PCT_W-1:0]   RST_LOW_EXIT      = 7'd25;

  localparam logic [PCT_W-1:0] PERCENT_MAX = 7'd100;

  // Charge state codes
  localparam logic [STATE_W-1:0] CHG_UNKNOWN     = 2'd0;
  localparam logic [STATE_W-1:0] CHG_CHARGING    = 2'd1;
  localparam logic [STATE_W-1:0] CHG_DISCHARGING = 2'd2;
  localparam logic [STATE_W-1:0] CHG_IDLE        = 2'd3;

endpackage
`default_nettype wire

/* sv/bgm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bgm_ram
// Generic single-write, single-read RAM with a registered read port that
// updates only on a read enable.
// ----------------------------------------------------------------------------
module bgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/battery_gauge_reading_monitor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// battery_gauge_reading_monitor
// Converts gauge readings to millivolts and percent, checks plausibility,
// tracks a voltage window for trend and keeps a low-battery latch.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+-------------------------------
//  in_      | input     | in_valid/in_ready   | vcell_word, raw_soc, read_ok
//  out_     | output    | out_valid/out_ready | reading_valid, percent,
//           |           |                     | millivolts, charge_state,
//           |           |                     | low_battery, low_entered
//  cfg_     | input     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
//  Throughput: one transaction per clock while out_ready is held high; a result
//  passes through the multiply stage, window stage and output register. The
//  rate is set by the window RAM, which takes one read and at most one write
//  per item, both in the same cycle.
//  Reset: control state and configuration registers clear at once; the window RAM is not
//  cleared, since the fill count keeps unwritten entries from being used.
//  Stalls: out_ready low holds the output register; each stage advances when
//  the one after it frees up, so in_ready only drops with all stages full.
//
module battery_gauge_reading_monitor #(
  parameter int WINDOW_SAMPLES = bgm_pkg::WINDOW_SAMPLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input transactions
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bgm_pkg::RAW_W-1:0]     in_vcell_word,
  input  wire logic [bgm_pkg::RAW_W-1:0]     in_raw_soc,
  input  wire logic                          in_read_ok,
  // result transactions
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_reading_valid,
  output logic      [bgm_pkg::PCT_W-1:0]     out_percent,
  output logic      [bgm_pkg::MV_W-1:0]      out_millivolts,
  output logic      [bgm_pkg::STATE_W-1:0]   out_charge_state,
  output logic                               out_low_battery,
  output logic                               out_low_entered,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [bgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bgm_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int WIN_AW = $clog2(WINDOW_SAMPLES);
  localparam int FILL_W = $clog2(WINDOW_SAMPLES + 1);
  localparam int PROD_W = bgm_pkg::RAW_W + bgm_pkg::SCALE_W;
  localparam int DIFF_W = bgm_pkg::MV_W + 2;

  localparam logic [WIN_AW-1:0] SLOT_LAST = WIN_AW'(WINDOW_SAMPLES - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SAMPLES);
  localparam logic [FILL_W-1:0] FILL_PRE  = FILL_W'(WINDOW_SAMPLES - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bgm_pkg::SHIFT_W-1:0] vcell_shift_r;
  logic [bgm_pkg::SCALE_W-1:0] mv_per_count_r;
  logic [bgm_pkg::MV_W-1:0]    max_mv_r;
  logic [bgm_pkg::SOC_W-1:0]   max_soc_r;
  logic [bgm_pkg::MV_W-1:0]    deadband_r;
  logic [bgm_pkg::PCT_W-1:0]   low_enter_r;
  logic [bgm_pkg::PCT_W-1:0]   low_exit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcell_shift_r  <= bgm_pkg::RST_VCELL_SHIFT;
      mv_per_count_r <= bgm_pkg::RST_MV_PER_COUNT;
      max_mv_r       <= bgm_pkg::RST_MAX_MV;
      max_soc_r      <= bgm_pkg::RST_MAX_SOC_WHOLE;
      deadband_r     <= bgm_pkg::RST_DEADBAND_MV;
      low_enter_r    <= bgm_pkg::RST_LOW_ENTER;
      low_exit_r     <= bgm_pkg::RST_LOW_EXIT;
    end else if (cfg_we) begin
      // Keep the low bits of the data word; indexes past the list are dropped.
      unique case (cfg_index)
        bgm_pkg::REG_VCELL_SHIFT:   vcell_shift_r  <= cfg_wdata[bgm_pkg::SHIFT_W-1:0];
        bgm_pkg::REG_MV_PER_COUNT:  mv_per_count_r <= cfg_wdata[bgm_pkg::SCALE_W-1:0];
        bgm_pkg::REG_MAX_MV:        max_mv_r       <= cfg_wdata[bgm_pkg::MV_W-1:0];
        bgm_pkg::REG_MAX_SOC_WHOLE: max_soc_r      <= cfg_wdata[bgm_pkg::SOC_W-1:0];
        bgm_pkg::REG_DEADBAND_MV:   deadband_r     <= cfg_wdata[bgm_pkg::MV_W-1:0];
        bgm_pkg::REG_LOW_ENTER:     low_enter_r    <= cfg_wdata[bgm_pkg::PCT_W-1:0];
        bgm_pkg::REG_LOW_EXIT:      low_exit_r     <= cfg_wdata[bgm_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshakes: each stage loads when it is empty or drains this cycle
  // --------------------------------------------------------------------------
  logic a_v_r, b_v_r;
  logic a_go, b_go, o_go;

  assign o_go     = !out_valid || out_ready;
  assign b_go     = !b_v_r || o_go;
  assign a_go     = !a_v_r || b_go;
  assign in_ready = a_go;

  logic in_fire, a_fire, b_fire;
  assign in_fire = in_valid && in_ready;
  assign a_fire  = a_v_r && b_go;   // item moves from the multiply stage into the window stage
  assign b_fire  = b_v_r && o_go;   // item moves into the output register

  // --------------------------------------------------------------------------
  // Stage A: shift out converter counts and scale by the Q8 factor
  // --------------------------------------------------------------------------
  logic [bgm_pkg::RAW_W-1:0]     counts;
  logic [PROD_W-1:0]             product;
  logic [bgm_pkg::MV_FULL_W-1:0] a_mv_full_r;
  logic [bgm_pkg::SOC_W-1:0]     a_whole_r;
  logic                          a_ok_r;

  assign counts  = in_vcell_word >> vcell_shift_r;
  assign product = {{bgm_pkg::SCALE_W{1'b0}}, counts} * {{bgm_pkg::RAW_W{1'b0}}, mv_per_count_r};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_mv_full_r <= product[PROD_W-1:8];
      // Fraction byte never moves the whole percent; keep the high byte only.
      a_whole_r   <= in_raw_soc[bgm_pkg::RAW_W-1:bgm_pkg::RAW_W-bgm_pkg::SOC_W];
      a_ok_r      <= in_read_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: plausibility, window write/read, fill tracking, low latch
  // --------------------------------------------------------------------------
  logic                        a_valid;
  logic [bgm_pkg::PCT_W-1:0]   a_percent;
  logic [bgm_pkg::MV_W-1:0]    a_mv;

  assign a_valid = a_ok_r && (a_whole_r <= max_soc_r) &&
                   (a_mv_full_r <= {{(bgm_pkg::MV_FULL_W-bgm_pkg::MV_W){1'b0}}, max_mv_r});
  assign a_percent = (a_whole_r > {1'b0, bgm_pkg::PERCENT_MAX}) ? bgm_pkg::PERCENT_MAX
                                                                : a_whole_r[bgm_pkg::PCT_W-1:0];
  assign a_mv = a_mv_full_r[bgm_pkg::MV_W-1:0];

  logic [WIN_AW-1:0] slot_r, slot_nxt, slot_inc;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              low_r, low_nxt;
  logic              entered_nxt;
  logic              full_nxt;

  assign slot_inc = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  always_comb begin
    slot_nxt    = slot_r;
    fill_nxt    = fill_r;
    low_nxt     = low_r;
    entered_nxt = 1'b0;
    full_nxt    = 1'b0;
    if (a_fire) begin
      if (!a_valid) begin
        // Drop the window history; the latch holds.
        slot_nxt = '0;
        fill_nxt = '0;
      end else begin
        slot_nxt = slot_inc;
        if (fill_r != FILL_FULL) begin
          fill_nxt = fill_r + 1'b1;
        end
        full_nxt = (fill_r == FILL_FULL) || (fill_r == FILL_PRE);
        if (low_r) begin
          if (a_percent >= low_exit_r) begin
            low_nxt = 1'b0;
          end
        end else if (a_percent <= low_enter_r) begin
          low_nxt     = 1'b1;
          entered_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      slot_r <= '0;
      fill_r <= '0;
      low_r  <= 1'b0;
    end else begin
      if (a_go) begin
        a_v_r <= in_fire;
      end
      if (b_go) begin
        b_v_r <= a_v_r;
      end
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
      low_r  <= low_nxt;
    end
  end

  // The newest entry is this item's own value; the oldest sits in the slot
  // after the one being written, so one read per item covers the trend.
  // That slot was written by an earlier item, so no forwarding is needed.
  logic [bgm_pkg::MV_W-1:0] oldest_mv;

  bgm_ram #(
    .WIDTH (bgm_pkg::MV_W),
    .DEPTH (WINDOW_SAMPLES),
    .AW    (WIN_AW)
  ) u_window (
    .clk   (clk),
    .we    (a_fire && a_valid),
    .waddr (slot_r),
    .wdata (a_mv),
    .re    (a_fire),
    .raddr (slot_inc),
    .rdata (oldest_mv)
  );

  logic                      b_ok_r;
  logic [bgm_pkg::PCT_W-1:0] b_pct_r;
  logic [bgm_pkg::MV_W-1:0]  b_mv_r;
  logic                      b_full_r;
  logic                      b_low_r;
  logic                      b_ent_r;

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_ok_r   <= a_valid;
      b_pct_r  <= a_valid ? a_percent : '0;
      b_mv_r   <= a_valid ? a_mv : '0;
      b_full_r <= full_nxt;
      b_low_r  <= low_nxt;
      b_ent_r  <= entered_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: classify the trend and load the output register
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]     delta, db_pos, db_neg;
  logic [bgm_pkg::STATE_W-1:0]  trend;

  assign delta  = $signed({2'b00, b_mv_r}) - $signed({2'b00, oldest_mv});
  assign db_pos = $signed({2'b00, deadband_r});
  assign db_neg = -db_pos;

  always_comb begin
    if (!b_ok_r || !b_full_r) begin
      trend = bgm_pkg::CHG_UNKNOWN;
    end else if (delta > db_pos) begin
      trend = bgm_pkg::CHG_CHARGING;
    end else if (delta < db_neg) begin
      trend = bgm_pkg::CHG_DISCHARGING;
    end else begin
      trend = bgm_pkg::CHG_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (o_go) begin
      out_valid <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_reading_valid <= b_ok_r;
      out_percent       <= b_pct_r;
      out_millivolts    <= b_mv_r;
      out_charge_state  <= trend;
      out_low_battery   <= b_low_r;
      out_low_entered   <= b_ent_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill count past window depth");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FILL_FULL) |-> (slot_r == fill_r[WIN_AW-1:0]))
    else $error("write slot out of step with fill count before window is full");

  a_trend_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_charge_state != bgm_pkg::CHG_UNKNOWN)) |-> out_reading_valid)
    else $error("trend reported for an invalid reading");

  a_invalid_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reading_valid) |->
      ((out_percent == '0) && (out_millivolts == '0) && !out_low_entered))
    else $error("invalid reading carries nonzero payload");

  a_entered_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_low_entered) |-> out_low_battery)
    else $error("low entered without the latch set");
`endif

endmodule
`default_nettype wire

/* bench/battery_gauge_reading_monitor_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_gauge_reading_monitor_test
// Self-checking bench for the gauge reading monitor. A negedge driver feeds
// readings from a queue, a posedge monitor predicts each accepted reading's
// status and checks the outputs field by field, in order. Phases change the
// register settings (extremes included) and the idling on both channels.
// ----------------------------------------------------------------------------
module battery_gauge_reading_monitor_test;

  localparam int WINDOW = bgm_pkg::WINDOW_SAMPLES_DEF;

  typedef struct packed {
    logic [bgm_pkg::RAW_W-1:0] vcell_word;
    logic [bgm_pkg::RAW_W-1:0] raw_soc;
    logic                      read_ok;
  } gauge_reading_t;

  typedef struct packed {
    logic                        reading_valid;
    logic [bgm_pkg::PCT_W-1:0]   percent;
    logic [bgm_pkg::MV_W-1:0]    millivolts;
    logic [bgm_pkg::STATE_W-1:0] charge_state;
    logic                        low_battery;
    logic                        low_entered;
  } gauge_status_t;

  // Clock, reset and every block input start at known values.
  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_ready;
  logic [bgm_pkg::RAW_W-1:0]     in_vcell_word = '0;
  logic [bgm_pkg::RAW_W-1:0]     in_raw_soc    = '0;
  logic                          in_read_ok    = 1'b0;
  logic                          out_valid;
  logic                          out_ready     = 1'b0;
  logic                          out_reading_valid;
  logic [bgm_pkg::PCT_W-1:0]     out_percent;
  logic [bgm_pkg::MV_W-1:0]      out_millivolts;
  logic [bgm_pkg::STATE_W-1:0]   out_charge_state;
  logic                          out_low_battery;
  logic                          out_low_entered;
  logic                          cfg_we        = 1'b0;
  logic [bgm_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [bgm_pkg::CFG_DAT_W-1:0] cfg_wdata     = '0;

  // Register copies used by the status predictor.
  logic [bgm_pkg::SHIFT_W-1:0] cfg_shift     = bgm_pkg::RST_VCELL_SHIFT;
  logic [bgm_pkg::SCALE_W-1:0] cfg_scale     = bgm_pkg::RST_MV_PER_COUNT;
  logic [bgm_pkg::MV_W-1:0]    cfg_max_mv    = bgm_pkg::RST_MAX_MV;
  logic [bgm_pkg::SOC_W-1:0]   cfg_max_soc   = bgm_pkg::RST_MAX_SOC_WHOLE;
  logic [bgm_pkg::MV_W-1:0]    cfg_deadband  = bgm_pkg::RST_DEADBAND_MV;
  logic [bgm_pkg::PCT_W-1:0]   cfg_low_enter = bgm_pkg::RST_LOW_ENTER;
  logic [bgm_pkg::PCT_W-1:0]   cfg_low_exit  = bgm_pkg::RST_LOW_EXIT;

  // Predictor state: voltage ring, its write position and fill, low latch.
  logic [bgm_pkg::MV_W-1:0] mv_window [WINDOW];
  int unsigned              write_pos   = 0;
  int unsigned              fill_level  = 0;
  logic                     low_latched = 1'b0;

  gauge_reading_t pending_readings [$];
  gauge_status_t  expected_status  [$];
  int unsigned    readings_queued = 0;
  int unsigned    readings_taken  = 0;
  int unsigned    error_count     = 0;
  int unsigned    send_idle_pct   = 0;
  int unsigned    recv_stall_pct  = 0;
  logic           in_fire         = 1'b0;

  battery_gauge_reading_monitor #(
    .WINDOW_SAMPLES(WINDOW)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_vcell_word    (in_vcell_word),
    .in_raw_soc       (in_raw_soc),
    .in_read_ok       (in_read_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reading_valid(out_reading_valid),
    .out_percent      (out_percent),
    .out_millivolts   (out_millivolts),
    .out_charge_state (out_charge_state),
    .out_low_battery  (out_low_battery),
    .out_low_entered  (out_low_entered),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_error(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Compute the status of one accepted reading and advance the predictor
  // state exactly as the block must.
  function automatic gauge_status_t predict_status(gauge_reading_t rd);
    logic [bgm_pkg::SOC_W-1:0]                  whole;
    logic [bgm_pkg::RAW_W-1:0]                  counts;
    logic [bgm_pkg::RAW_W+bgm_pkg::SCALE_W-1:0] product;
    logic [bgm_pkg::MV_FULL_W-1:0]              mv_full;
    int                                         delta;
    int                                         band;
    gauge_status_t                              st;
    whole   = rd.raw_soc[bgm_pkg::RAW_W-1 -: bgm_pkg::SOC_W];
    counts  = rd.vcell_word >> cfg_shift;
    product = counts * cfg_scale;
    // Keep the full-width conversion: anything above 16 bits is implausible.
    mv_full = product[bgm_pkg::RAW_W+bgm_pkg::SCALE_W-1:8];
    st      = '0;
    if (!rd.read_ok || whole > cfg_max_soc || mv_full > cfg_max_mv) begin
      // Drop the window fill; the latch holds its value.
      write_pos       = 0;
      fill_level      = 0;
      st.charge_state = bgm_pkg::CHG_UNKNOWN;
      st.low_battery  = low_latched;
      return st;
    end
    st.reading_valid = 1'b1;
    st.percent       = (whole > bgm_pkg::PERCENT_MAX) ? bgm_pkg::PERCENT_MAX
                                                      : whole[bgm_pkg::PCT_W-1:0];
    st.millivolts    = mv_full[bgm_pkg::MV_W-1:0];
    mv_window[write_pos] = st.millivolts;
    write_pos = (write_pos + 1) % WINDOW;
    if (fill_level < WINDOW) begin
      fill_level++;
    end
    st.charge_state = bgm_pkg::CHG_UNKNOWN;
    if (fill_level >= WINDOW) begin
      // Newest minus oldest; after the advance the write position is the oldest.
      delta = int'(mv_window[(write_pos + WINDOW - 1) % WINDOW]) - int'(mv_window[write_pos]);
      band  = int'(cfg_deadband);
      if (delta > band) begin
        st.charge_state = bgm_pkg::CHG_CHARGING;
      end else if (delta < -band) begin
        st.charge_state = bgm_pkg::CHG_DISCHARGING;
      end else begin
        st.charge_state = bgm_pkg::CHG_IDLE;
      end
    end
    if (low_latched) begin
      if (st.percent >= cfg_low_exit) begin
        low_latched = 1'b0;
      end
    end else if (st.percent <= cfg_low_enter) begin
      low_latched    = 1'b1;
      st.low_entered = 1'b1;
    end
    st.low_battery = low_latched;
    return st;
  endfunction

  // Driver: change inputs on the falling edge. Hold a waiting transaction
  // until it is taken; otherwise pull the next reading or idle at random.
  always @(negedge clk) begin : driver
    gauge_reading_t staged;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!in_valid || in_fire) begin
      if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        staged         = pending_readings.pop_front();
        in_valid      <= 1'b1;
        in_vcell_word <= staged.vcell_word;
        in_raw_soc    <= staged.raw_soc;
        in_read_ok    <= staged.read_ok;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: sample both handshakes on the rising edge. Predict first, then
  // retire the oldest expectation against the result on the port.
  always @(posedge clk) begin : monitor
    gauge_status_t want;
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_status.push_back(predict_status('{vcell_word: in_vcell_word,
                                                   raw_soc:    in_raw_soc,
                                                   read_ok:    in_read_ok}));
        readings_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          report_error("result transaction with nothing expected");
        end else begin
          want = expected_status.pop_front();
          check_field("reading_valid", out_reading_valid, want.reading_valid);
          check_field("percent", out_percent, want.percent);
          check_field("millivolts", out_millivolts, want.millivolts);
          check_field("charge_state", out_charge_state, want.charge_state);
          check_field("low_battery", out_low_battery, want.low_battery);
          check_field("low_entered", out_low_entered, want.low_entered);
        end
      end
    end
  end

  // Write one register on the next falling edge and track it in the copy.
  task automatic write_reg(logic [bgm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 16'(val);
    case (idx)
      bgm_pkg::REG_VCELL_SHIFT:   cfg_shift     = val[bgm_pkg::SHIFT_W-1:0];
      bgm_pkg::REG_MV_PER_COUNT:  cfg_scale     = val[bgm_pkg::SCALE_W-1:0];
      bgm_pkg::REG_MAX_MV:        cfg_max_mv    = val[bgm_pkg::MV_W-1:0];
      bgm_pkg::REG_MAX_SOC_WHOLE: cfg_max_soc   = val[bgm_pkg::SOC_W-1:0];
      bgm_pkg::REG_DEADBAND_MV:   cfg_deadband  = val[bgm_pkg::MV_W-1:0];
      bgm_pkg::REG_LOW_ENTER:     cfg_low_enter = val[bgm_pkg::PCT_W-1:0];
      bgm_pkg::REG_LOW_EXIT:      cfg_low_exit  = val[bgm_pkg::PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(int unsigned shift, int unsigned scale, int unsigned max_mv,
                              int unsigned max_soc, int unsigned band,
                              int unsigned enter_pct, int unsigned exit_pct);
    write_reg(bgm_pkg::REG_VCELL_SHIFT, shift);
    write_reg(bgm_pkg::REG_MV_PER_COUNT, scale);
    write_reg(bgm_pkg::REG_MAX_MV, max_mv);
    write_reg(bgm_pkg::REG_MAX_SOC_WHOLE, max_soc);
    write_reg(bgm_pkg::REG_DEADBAND_MV, band);
    write_reg(bgm_pkg::REG_LOW_ENTER, enter_pct);
    write_reg(bgm_pkg::REG_LOW_EXIT, exit_pct);
  endtask

  task automatic queue_reading(logic [bgm_pkg::RAW_W-1:0] vcell,
                               logic [bgm_pkg::RAW_W-1:0] soc, logic ok);
    pending_readings.push_back('{vcell_word: vcell, raw_soc: soc, read_ok: ok});
    readings_queued++;
  endtask

  // Block until every queued reading was taken and every result came back.
  task automatic wait_drained();
    while (readings_taken != readings_queued || expected_status.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Largest raw voltage word whose conversion still passes the mV limit.
  function automatic int unsigned plausible_vcell_limit();
    longint unsigned max_counts;
    longint unsigned limit;
    if (cfg_scale == 0) begin
      return 65535;
    end
    max_counts = (longint'(cfg_max_mv) + 1) * 256 - 1;
    max_counts = max_counts / cfg_scale;
    limit = ((max_counts + 1) << cfg_shift) - 1;
    return (limit > 65535) ? 65535 : int'(limit);
  endfunction

  // One noise reading, usually broken: failed read, charge over limit, voltage over limit,
  // or plain random words.
  task automatic queue_noise();
    int unsigned lim;
    int unsigned whole;
    lim = plausible_vcell_limit();
    case ($urandom_range(3))
      0: queue_reading(16'($urandom), 16'($urandom), 1'b0);
      1: begin
        whole = (cfg_max_soc < 255) ? $urandom_range(cfg_max_soc + 1, 255) : $urandom_range(255);
        queue_reading(16'($urandom_range(lim)), {whole[7:0], 8'($urandom)}, 1'b1);
      end
      2: begin
        whole = $urandom_range(cfg_max_soc);
        queue_reading(16'((lim < 65535) ? $urandom_range(lim + 1, 65535) : $urandom),
                      {whole[7:0], 8'($urandom)}, 1'b1);
      end
      default: queue_reading(16'($urandom), 16'($urandom), 1'($urandom));
    endcase
  endtask

  // A run of plausible readings long enough to fill the window, with a
  // voltage ramp (up, down or flat) and a charge walk that often starts near
  // the low-battery threshold. Now and then break the run with noise.
  task automatic queue_run();
    int unsigned lim;
    int unsigned len;
    int          vcell;
    int          step;
    int          whole;
    int          span;
    lim   = plausible_vcell_limit();
    len   = $urandom_range(8, 24);
    vcell = $urandom_range(lim);
    span  = $urandom_range(lim / 16 + 2);
    step  = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? $urandom_range(span)
                                                           : -int'($urandom_range(span)));
    whole = $urandom_range(1) ? int'(cfg_low_enter) + int'($urandom_range(10)) - 5
                              : int'($urandom_range(cfg_max_soc));
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        queue_noise();
      end
      if (whole < 0) whole = 0;
      if (whole > int'(cfg_max_soc)) whole = cfg_max_soc;
      if (vcell < 0) vcell = 0;
      if (vcell > int'(lim)) vcell = lim;
      queue_reading(vcell[bgm_pkg::RAW_W-1:0], {whole[7:0], 8'($urandom)}, 1'b1);
      vcell = vcell + step + int'($urandom_range(3)) - 1;
      whole = whole + int'($urandom_range(6)) - 3;
    end
  endtask

  // Phase idling: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  initial begin : sequencer
    int unsigned target;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: raw word shifted right by 4, 1.25 mV
    // per count, limits 5000 mV / 110 whole, deadband 20, enter 20, exit 25.
    set_idling(0);
    queue_reading(16'h0000, {8'd0, 8'h00}, 1'b1);    // zero reading latches low
    queue_reading(16'hFFFF, 16'hFFFF, 1'b0);          // failed read keeps latch
    queue_reading(16'd64015, {8'd110, 8'hFF}, 1'b1);  // both limits exactly, clamp
    queue_reading(16'd64016, {8'd50, 8'h00}, 1'b1);   // one mV over
    queue_reading(16'd1000, {8'd111, 8'h00}, 1'b1);   // whole byte over
    queue_reading(16'hFFFF, {8'd50, 8'h80}, 1'b1);    // full-scale voltage
    // Fill from empty: seven flat, then exactly the deadband (idle), then one
    // past it (charging). Percent walks across enter and exit thresholds.
    queue_reading(16'h000F, {8'd30, 8'hFF}, 1'b1);
    queue_reading(16'h0000, {8'd21, 8'h01}, 1'b1);
    queue_reading(16'h0007, {8'd20, 8'hFF}, 1'b1);
    queue_reading(16'h0000, {8'd19, 8'h00}, 1'b1);
    queue_reading(16'h0000, {8'd24, 8'hFF}, 1'b1);
    queue_reading(16'h0000, {8'd25, 8'h00}, 1'b1);
    queue_reading(16'h0000, {8'd26, 8'h10}, 1'b1);
    queue_reading(16'h010F, {8'd21, 8'h00}, 1'b1);
    queue_reading(16'h0110, {8'd20, 8'h00}, 1'b1);
    queue_reading(16'h1234, {8'd10, 8'h00}, 1'b0);    // clear the window
    // Refill: one past the deadband downward, then exactly the deadband.
    queue_reading(16'h0110, {8'd24, 8'h00}, 1'b1);
    queue_reading(16'h0100, {8'd25, 8'h00}, 1'b1);
    queue_reading(16'h0100, {8'd22, 8'h00}, 1'b1);
    queue_reading(16'h0100, {8'd21, 8'h00}, 1'b1);
    queue_reading(16'h0100, {8'd20, 8'h00}, 1'b1);
    queue_reading(16'h0100, {8'd0, 8'hFF}, 1'b1);
    queue_reading(16'h0100, {8'd100, 8'h00}, 1'b1);
    queue_reading(16'h0000, {8'd110, 8'h00}, 1'b1);
    queue_reading(16'h0000, {8'd0, 8'h00}, 1'b1);
    wait_drained();

    // Random phases: extremes first, then reset values, then random settings.
    for (int unsigned stage_idx = 0; stage_idx < 8; stage_idx++) begin
      case (stage_idx)
        0: apply_config(15, 4095, 65535, 255, 0, 100, 0);
        1: apply_config(0, 0, 0, 0, 65535, 0, 100);
        2: apply_config(0, 4095, 0, 255, 0, 100, 100);
        3: apply_config(bgm_pkg::RST_VCELL_SHIFT, bgm_pkg::RST_MV_PER_COUNT,
                        bgm_pkg::RST_MAX_MV, bgm_pkg::RST_MAX_SOC_WHOLE,
                        bgm_pkg::RST_DEADBAND_MV, bgm_pkg::RST_LOW_ENTER,
                        bgm_pkg::RST_LOW_EXIT);
        default: apply_config($urandom_range(15), $urandom_range(4095),
                              $urandom_range(3) == 0 ? 65535 : $urandom_range(500, 65535),
                              $urandom_range(80, 255),
                              $urandom_range(3) == 0 ? $urandom_range(65535)
                                                     : $urandom_range(80),
                              $urandom_range(100), $urandom_range(100));
      endcase
      set_idling(stage_idx % 4);
      target = readings_queued + 105;
      while (readings_queued < target) begin
        queue_run();
        repeat ($urandom_range(2)) queue_noise();
      end
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (16) @(negedge clk);
    if (expected_status.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_status.size()));
    end
    if (error_count == 0) begin
      $display("battery_gauge_reading_monitor regression: pass");
    end else begin
      $display("battery_gauge_reading_monitor regression: fail");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("battery_gauge_reading_monitor regression: fail");
    $finish;
  end

endmodule
